// File: rtl/tll_pkg.sv
package tll_pkg;

    localparam int CHILD_W      = 4;
    localparam int RESULT_LIMIT = 16;
    localparam int LEAF_AW      = $clog2(RESULT_LIMIT);
    localparam int LEAF_CW      = $clog2(RESULT_LIMIT + 1);

    typedef struct packed {
        logic               valid;
        logic [CHILD_W-1:0] idx;
    } t_child;

    typedef struct packed {
        t_child left;
        t_child right;
    } t_node_entry;

    localparam int ENTRY_W = $bits(t_node_entry);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_QREAD,
        S_TREAD,
        S_CHECK,
        S_PUSHL,
        S_PUSHR,
        S_LREAD,
        S_LOUT,
        S_ERR
    } t_state;

endpackage

// File: rtl/tll_ram.sv
module tll_ram #(
    parameter int DEPTH,
    parameter int WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tll_walk_ctrl.sv
module tll_walk_ctrl #(
    parameter int MAX_NODES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_has_left,
    input  logic [tll_pkg::CHILD_W-1:0]      i_left_child,
    input  logic                             i_has_right,
    input  logic [tll_pkg::CHILD_W-1:0]      i_right_child,
    input  logic                             i_final_node,
    output logic                             o_result_valid,
    output logic [tll_pkg::CHILD_W-1:0]      o_leaf_node,
    output logic                             o_last_leaf,
    output logic                             o_walk_error,
    // node table
    output logic                             o_tbl_we,
    output logic [$clog2(MAX_NODES)-1:0]     o_tbl_waddr,
    output tll_pkg::t_node_entry             o_tbl_wdata,
    output logic [$clog2(MAX_NODES)-1:0]     o_tbl_raddr,
    input  tll_pkg::t_node_entry             i_tbl_rdata,
    // walk queue
    output logic                             o_q_we,
    output logic [$clog2(MAX_NODES)-1:0]     o_q_waddr,
    output logic [$clog2(MAX_NODES)-1:0]     o_q_wdata,
    output logic [$clog2(MAX_NODES)-1:0]     o_q_raddr,
    input  logic [$clog2(MAX_NODES)-1:0]     i_q_rdata,
    // leaf buffer
    output logic                             o_lf_we,
    output logic [tll_pkg::LEAF_AW-1:0]      o_lf_waddr,
    output logic [$clog2(MAX_NODES)-1:0]     o_lf_wdata,
    output logic [tll_pkg::LEAF_AW-1:0]      o_lf_raddr,
    input  logic [$clog2(MAX_NODES)-1:0]     i_lf_rdata
);

    import tll_pkg::*;

    localparam int NW   = $clog2(MAX_NODES);
    localparam int CW   = $clog2(MAX_NODES + 1);
    localparam int CMPW = (CW > CHILD_W) ? CW : CHILD_W;

    t_state                r_state, n_state;
    logic [MAX_NODES-1:0]  r_ref, n_ref;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_tail, n_tail;
    logic [NW-1:0]         r_scan, n_scan;
    logic [NW-1:0]         r_node, n_node;
    t_node_entry           r_entry, n_entry;
    logic [LEAF_CW-1:0]    r_nleaf, n_nleaf;
    logic [LEAF_AW-1:0]    r_eidx, n_eidx;

    logic                  leaf_last;
    logic [CMPW-1:0]       leaf_ext;
    logic                  left_ok;
    logic                  right_ok;
    logic                  tail_ok;

    assign busy        = (r_state != S_IDLE);
    assign leaf_last   = (LEAF_CW'(r_eidx) + LEAF_CW'(1)) == r_nleaf;
    assign leaf_ext    = CMPW'(i_lf_rdata);
    assign tail_ok     = r_tail < CW'(MAX_NODES);
    assign left_ok     = CMPW'(r_entry.left.idx) < CMPW'(r_count);
    assign right_ok    = CMPW'(r_entry.right.idx) < CMPW'(r_count);

    assign o_tbl_waddr = NW'(r_count);
    assign o_tbl_raddr = i_q_rdata;
    assign o_q_raddr   = NW'(r_head);
    assign o_lf_waddr  = LEAF_AW'(r_nleaf);
    assign o_lf_wdata  = r_node;
    assign o_lf_raddr  = r_eidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ref   <= '0;
            r_count <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_nleaf <= '0;
            r_eidx  <= '0;
        end else begin
            r_state <= n_state;
            r_ref   <= n_ref;
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_nleaf <= n_nleaf;
            r_eidx  <= n_eidx;
        end
        r_scan  <= n_scan;
        r_node  <= n_node;
        r_entry <= n_entry;
    end

    always_comb begin
        n_state        = r_state;
        n_ref          = r_ref;
        n_count        = r_count;
        n_head         = r_head;
        n_tail         = r_tail;
        n_scan         = r_scan;
        n_node         = r_node;
        n_entry        = r_entry;
        n_nleaf        = r_nleaf;
        n_eidx         = r_eidx;
        o_tbl_we       = 1'b0;
        o_tbl_wdata    = '{left:  '{valid: i_has_left,  idx: i_left_child},
                           right: '{valid: i_has_right, idx: i_right_child}};
        o_q_we         = 1'b0;
        o_q_waddr      = NW'(r_tail);
        o_q_wdata      = r_scan;
        o_lf_we        = 1'b0;
        o_result_valid = 1'b0;
        o_leaf_node    = leaf_ext[CHILD_W-1:0];
        o_last_leaf    = leaf_last;
        o_walk_error   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    // a full table ignores the transaction but still honors final_node
                    if (r_count < CW'(MAX_NODES)) begin
                        o_tbl_we = 1'b1;
                        n_count  = r_count + CW'(1);
                        for (int i = 0; i < MAX_NODES; i++) begin
                            if (i_has_left && CMPW'(i_left_child) == CMPW'(i)) begin
                                n_ref[i] = 1'b1;
                            end
                            if (i_has_right && CMPW'(i_right_child) == CMPW'(i)) begin
                                n_ref[i] = 1'b1;
                            end
                        end
                    end
                    if (i_final_node) begin
                        n_scan  = NW'(n_count - CW'(1));
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // highest unreferenced node becomes the root
                if (!r_ref[r_scan]) begin
                    o_q_we    = 1'b1;
                    o_q_waddr = '0;
                    n_head    = '0;
                    n_tail    = CW'(1);
                    n_nleaf   = '0;
                    n_state   = S_QREAD;
                end else if (r_scan == '0) begin
                    n_state = S_ERR;
                end else begin
                    n_scan = r_scan - NW'(1);
                end
            end
            S_QREAD: begin
                if (r_head == r_tail) begin
                    n_eidx  = '0;
                    n_state = S_LREAD;
                end else begin
                    n_state = S_TREAD;
                end
            end
            S_TREAD: begin
                n_node  = i_q_rdata;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_entry = i_tbl_rdata;
                if (!i_tbl_rdata.left.valid && !i_tbl_rdata.right.valid) begin
                    if (r_nleaf == LEAF_CW'(RESULT_LIMIT)) begin
                        n_state = S_ERR;
                    end else begin
                        o_lf_we = 1'b1;
                        n_nleaf = r_nleaf + LEAF_CW'(1);
                        n_head  = r_head + CW'(1);
                        n_state = S_QREAD;
                    end
                end else if (i_tbl_rdata.left.valid) begin
                    n_state = S_PUSHL;
                end else begin
                    n_state = S_PUSHR;
                end
            end
            S_PUSHL: begin
                if (!left_ok || !tail_ok) begin
                    n_state = S_ERR;
                end else begin
                    o_q_we    = 1'b1;
                    o_q_wdata = NW'(r_entry.left.idx);
                    n_tail    = r_tail + CW'(1);
                    if (r_entry.right.valid) begin
                        n_state = S_PUSHR;
                    end else begin
                        n_head  = r_head + CW'(1);
                        n_state = S_QREAD;
                    end
                end
            end
            S_PUSHR: begin
                if (!right_ok || !tail_ok) begin
                    n_state = S_ERR;
                end else begin
                    o_q_we    = 1'b1;
                    o_q_wdata = NW'(r_entry.right.idx);
                    n_tail    = r_tail + CW'(1);
                    n_head    = r_head + CW'(1);
                    n_state   = S_QREAD;
                end
            end
            S_LREAD: begin
                n_state = S_LOUT;
            end
            S_LOUT: begin
                o_result_valid = 1'b1;
                if (leaf_last) begin
                    n_ref   = '0;
                    n_count = '0;
                    n_head  = '0;
                    n_tail  = '0;
                    n_nleaf = '0;
                    n_state = S_IDLE;
                end else begin
                    n_eidx  = r_eidx + LEAF_AW'(1);
                    n_state = S_LREAD;
                end
            end
            S_ERR: begin
                o_result_valid = 1'b1;
                o_leaf_node    = '0;
                o_last_leaf    = 1'b1;
                o_walk_error   = 1'b1;
                n_ref          = '0;
                n_count        = '0;
                n_head         = '0;
                n_tail         = '0;
                n_nleaf        = '0;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result strobe outside a run");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_walk_error) |-> o_last_leaf)
        else $error("error result not marked last");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last_leaf) |=> (!busy && r_count == '0 && r_ref == '0))
        else $error("run state not cleared after final result");

    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");

    a_leaf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nleaf <= LEAF_CW'(RESULT_LIMIT))
        else $error("leaf count beyond limit");
`endif

endmodule

// File: rtl/tree_leaf_level_order_lister.sv
// Loads a binary tree one node per transaction (start while busy is low) and,
// on the transaction with final_node set, picks the highest unreferenced node
// as root, walks the tree breadth first and lists its leaves in level order.
// Results are single-cycle strobes on o_result_valid that the receiver cannot
// hold off; the run ends with o_last_leaf, and a failed run (no root, child not
// loaded, queue overflow, more than 16 leaves) gives one result with
// o_walk_error set. busy stays high from the final transaction until the last
// result. A run first scans the loaded nodes from the highest down for the
// root, then for each visited node reads the walk queue and the node table,
// both with a registered read port, and pushes its children through the single
// write port of the queue until it finds the queue empty; it then reads each
// leaf back from the leaf buffer and puts it out.
module tree_leaf_level_order_lister #(
    parameter int MAX_NODES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_has_left,
    input  logic [tll_pkg::CHILD_W-1:0] i_left_child,
    input  logic                        i_has_right,
    input  logic [tll_pkg::CHILD_W-1:0] i_right_child,
    input  logic                        i_final_node,
    output logic                        o_result_valid,
    output logic [tll_pkg::CHILD_W-1:0] o_leaf_node,
    output logic                        o_last_leaf,
    output logic                        o_walk_error
);

    import tll_pkg::*;

    localparam int NW = $clog2(MAX_NODES);

    logic               tbl_we;
    logic [NW-1:0]      tbl_waddr;
    t_node_entry        tbl_wdata;
    logic [NW-1:0]      tbl_raddr;
    logic [ENTRY_W-1:0] tbl_rdata;
    logic               q_we;
    logic [NW-1:0]      q_waddr;
    logic [NW-1:0]      q_wdata;
    logic [NW-1:0]      q_raddr;
    logic [NW-1:0]      q_rdata;
    logic               lf_we;
    logic [LEAF_AW-1:0] lf_waddr;
    logic [NW-1:0]      lf_wdata;
    logic [LEAF_AW-1:0] lf_raddr;
    logic [NW-1:0]      lf_rdata;

    tll_walk_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_has_left     (i_has_left),
        .i_left_child   (i_left_child),
        .i_has_right    (i_has_right),
        .i_right_child  (i_right_child),
        .i_final_node   (i_final_node),
        .o_result_valid (o_result_valid),
        .o_leaf_node    (o_leaf_node),
        .o_last_leaf    (o_last_leaf),
        .o_walk_error   (o_walk_error),
        .o_tbl_we       (tbl_we),
        .o_tbl_waddr    (tbl_waddr),
        .o_tbl_wdata    (tbl_wdata),
        .o_tbl_raddr    (tbl_raddr),
        .i_tbl_rdata    (t_node_entry'(tbl_rdata)),
        .o_q_we         (q_we),
        .o_q_waddr      (q_waddr),
        .o_q_wdata      (q_wdata),
        .o_q_raddr      (q_raddr),
        .i_q_rdata      (q_rdata),
        .o_lf_we        (lf_we),
        .o_lf_waddr     (lf_waddr),
        .o_lf_wdata     (lf_wdata),
        .o_lf_raddr     (lf_raddr),
        .i_lf_rdata     (lf_rdata)
    );

    tll_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (ENTRY_W)
    ) u_node_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (ENTRY_W'(tbl_wdata)),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    tll_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (NW)
    ) u_walk_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    tll_ram #(
        .DEPTH (RESULT_LIMIT),
        .WIDTH (NW)
    ) u_leaf_buf (
        .i_clk   (i_clk),
        .i_we    (lf_we),
        .i_waddr (lf_waddr),
        .i_wdata (lf_wdata),
        .i_raddr (lf_raddr),
        .o_rdata (lf_rdata)
    );

endmodule

// File: bench/tb_tree_leaf_level_order_lister.sv
module tb_tree_leaf_level_order_lister;
    timeunit 1ns;
    timeprecision 1ps;

    import tll_pkg::*;

    localparam int MAX_NODES    = 16;
    localparam int ITEM_GOAL    = 480;
    localparam int GAP_MAX      = 17;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        logic [CHILD_W-1:0] leaf;
        logic               last;
        logic               err;
    } t_leaf_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_has_left;
    logic [CHILD_W-1:0] i_left_child;
    logic               i_has_right;
    logic [CHILD_W-1:0] i_right_child;
    logic               i_final_node;
    logic               o_result_valid;
    logic [CHILD_W-1:0] o_leaf_node;
    logic               o_last_leaf;
    logic               o_walk_error;

    // tree image kept by the predictor
    t_child left_tab  [MAX_NODES];
    t_child right_tab [MAX_NODES];
    bit     referenced [MAX_NODES];
    int     loaded_nodes;

    t_leaf_result leaf_results_due [$];
    t_leaf_result due;

    int mismatches;
    int items_sent;
    int max_gap;
    int cycle_count;

    tree_leaf_level_order_lister #(.MAX_NODES(MAX_NODES)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_has_left     (i_has_left),
        .i_left_child   (i_left_child),
        .i_has_right    (i_has_right),
        .i_right_child  (i_right_child),
        .i_final_node   (i_final_node),
        .o_result_valid (o_result_valid),
        .o_leaf_node    (o_leaf_node),
        .o_last_leaf    (o_last_leaf),
        .o_walk_error   (o_walk_error)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    function automatic void clear_tree();
        for (int i = 0; i < MAX_NODES; i++) begin
            referenced[i] = 1'b0;
        end
        loaded_nodes = 0;
    endfunction

    function automatic void push_walk_error();
        t_leaf_result r;
        r.leaf = '0;
        r.last = 1'b1;
        r.err  = 1'b1;
        leaf_results_due = {leaf_results_due, r};
    endfunction

    // load one node and, on the final one, walk the tree breadth first
    function automatic void predict_node(input logic hl, input logic [CHILD_W-1:0] lc,
                                         input logic hr, input logic [CHILD_W-1:0] rc,
                                         input logic fin);
        int           walk_q [MAX_NODES];
        int           head;
        int           tail;
        int           root;
        int           node;
        bit           found;
        bit           failed;
        int           leaves [$];
        t_leaf_result r;
        t_child       l;
        t_child       rt;

        if (loaded_nodes < MAX_NODES) begin
            left_tab[loaded_nodes].valid  = hl;
            left_tab[loaded_nodes].idx    = hl ? lc : '0;
            right_tab[loaded_nodes].valid = hr;
            right_tab[loaded_nodes].idx   = hr ? rc : '0;
            if (hl) referenced[lc] = 1'b1;
            if (hr) referenced[rc] = 1'b1;
            loaded_nodes++;
        end
        if (!fin) return;

        found = 1'b0;
        root  = 0;
        for (int i = 0; i < loaded_nodes; i++) begin
            if (!referenced[i]) begin
                root  = i;
                found = 1'b1;
            end
        end
        if (!found) begin
            push_walk_error();
            clear_tree();
            return;
        end

        failed    = 1'b0;
        walk_q[0] = root;
        head      = 0;
        tail      = 1;
        while (head < tail && !failed) begin
            node = walk_q[head];
            l    = left_tab[node];
            rt   = right_tab[node];
            if (!l.valid && !rt.valid) begin
                if (leaves.size() >= RESULT_LIMIT) failed = 1'b1;
                else leaves = {leaves, node};
            end
            if (!failed && l.valid) begin
                // linear queue: any push past its depth is an overflow
                if (l.idx >= loaded_nodes || tail >= MAX_NODES) failed = 1'b1;
                else walk_q[tail++] = l.idx;
            end
            if (!failed && rt.valid) begin
                if (rt.idx >= loaded_nodes || tail >= MAX_NODES) failed = 1'b1;
                else walk_q[tail++] = rt.idx;
            end
            head++;
        end

        if (failed) begin
            push_walk_error();
        end else begin
            foreach (leaves[i]) begin
                r.leaf = CHILD_W'(leaves[i]);
                r.last = (i == leaves.size() - 1);
                r.err  = 1'b0;
                leaf_results_due = {leaf_results_due, r};
            end
        end
        clear_tree();
    endfunction

    task automatic send_node(input logic hl, input logic [CHILD_W-1:0] lc,
                             input logic hr, input logic [CHILD_W-1:0] rc,
                             input logic fin);
        int gap;
        gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_has_left    <= hl;
        i_left_child  <= lc;
        i_has_right   <= hr;
        i_right_child <= rc;
        i_final_node  <= fin;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_node(hl, lc, hr, rc, fin);
        items_sent++;
    endtask

    // mostly acyclic trees whose children come from earlier unreferenced nodes
    task automatic send_tree(input int n, input bit noisy);
        int                 avail [$];
        int                 pick;
        logic               hl;
        logic               hr;
        logic [CHILD_W-1:0] lc;
        logic [CHILD_W-1:0] rc;
        for (int i = 0; i < n; i++) begin
            lc = CHILD_W'($urandom_range(0, 15));
            rc = CHILD_W'($urandom_range(0, 15));
            hl = 1'b0;
            hr = 1'b0;
            if (noisy && $urandom_range(0, 3) == 0) begin
                hl = 1'($urandom_range(0, 1));
                hr = 1'($urandom_range(0, 1));
            end else begin
                if (avail.size() > 0 && $urandom_range(0, 9) < 7) begin
                    pick = $urandom_range(0, avail.size() - 1);
                    lc   = CHILD_W'(avail[pick]);
                    avail.delete(pick);
                    hl   = 1'b1;
                end
                if (avail.size() > 0 && $urandom_range(0, 9) < 7) begin
                    pick = $urandom_range(0, avail.size() - 1);
                    rc   = CHILD_W'(avail[pick]);
                    avail.delete(pick);
                    hr   = 1'b1;
                end
            end
            if (i < MAX_NODES) avail = {avail, i};
            send_node(hl, lc, hr, rc, i == n - 1);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (leaf_results_due.size() == 0) begin
                report_mismatch("unexpected result, leaf", o_leaf_node, 0);
            end else begin
                due = leaf_results_due.pop_front();
                if (o_leaf_node !== due.leaf) report_mismatch("leaf_node", o_leaf_node, due.leaf);
                if (o_last_leaf !== due.last) report_mismatch("last_leaf", o_last_leaf, due.last);
                if (o_walk_error !== due.err) report_mismatch("walk_error", o_walk_error, due.err);
            end
        end
    end

    task automatic test_directed_cases();
        max_gap = GAP_MAX;
        // lone node, ignored child fields at max
        send_node(1'b0, 4'd15, 1'b0, 4'd15, 1'b1);
        // node names itself: no root
        send_node(1'b1, 4'd0, 1'b0, 4'd0, 1'b1);
        // child never loaded
        send_node(1'b0, 4'd0, 1'b1, 4'd15, 1'b1);
        send_node(1'b1, 4'd15, 1'b1, 4'd15, 1'b1);
        // self loop below the root overflows the queue
        send_node(1'b1, 4'd1, 1'b0, 4'd0, 1'b0);
        send_node(1'b1, 4'd1, 1'b0, 4'd0, 1'b0);
        send_node(1'b1, 4'd0, 1'b0, 4'd0, 1'b1);
        // shared child listed twice
        send_node(1'b0, 4'd0, 1'b0, 4'd0, 1'b0);
        send_node(1'b1, 4'd0, 1'b1, 4'd0, 1'b1);
        // balanced tree of seven
        for (int i = 0; i < 4; i++) begin
            send_node(1'b0, 4'd15, 1'b0, 4'd15, 1'b0);
        end
        send_node(1'b1, 4'd0, 1'b1, 4'd1, 1'b0);
        send_node(1'b1, 4'd2, 1'b1, 4'd3, 1'b0);
        send_node(1'b1, 4'd4, 1'b1, 4'd5, 1'b1);
    endtask

    task automatic test_drain_pause();
        max_gap = 0;
        send_tree(6, 1'b0);
        // release start so the finished transaction is not taken again once busy drops
        @(negedge i_clk);
        start <= 1'b0;
        while (leaf_results_due.size() > 0) @(posedge i_clk);
        send_tree(MAX_NODES, 1'b0);
        send_tree(3, 1'b0);
    endtask

    task automatic test_random_trees();
        int n;
        int pick;
        while (items_sent < ITEM_GOAL) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) n = $urandom_range(1, 8);
            else if (pick < 95) n = $urandom_range(9, MAX_NODES);
            else n = $urandom_range(MAX_NODES + 1, MAX_NODES + 4);
            max_gap = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            send_tree(n, $urandom_range(0, 4) == 0);
        end
    endtask

    initial begin
        int waited;
        mismatches    = 0;
        items_sent    = 0;
        cycle_count   = 0;
        max_gap       = GAP_MAX;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_has_left    = 1'b0;
        i_left_child  = '0;
        i_has_right   = 1'b0;
        i_right_child = '0;
        i_final_node  = 1'b0;
        clear_tree();
        for (int i = 0; i < MAX_NODES; i++) begin
            left_tab[i]  = '0;
            right_tab[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_drain_pause();
        test_random_trees();

        @(negedge i_clk);
        start <= 1'b0;
        waited = 0;
        while (leaf_results_due.size() > 0 && waited < CYCLE_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (leaf_results_due.size() > 0)
            report_mismatch("results never seen, count", 0, leaf_results_due.size());

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/tll_pkg.sv
rtl/tll_ram.sv
rtl/tll_walk_ctrl.sv
rtl/tree_leaf_level_order_lister.sv
bench/tb_tree_leaf_level_order_lister.sv
